// ===== sv/ilst_pkg.sv =====
// Package for the indexed insert/delete list core.
// Holds the list capacity, derived widths, action codes and channel structs.
// No dependencies.
package ilst_pkg;

  // List capacity and the widths that follow from it.
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 7;
  localparam int DATA_W   = 32;

  // Action codes of a request.
  localparam logic [2:0] ACT_GET      = 3'd0;
  localparam logic [2:0] ACT_INS_IDX  = 3'd1;
  localparam logic [2:0] ACT_INS_HEAD = 3'd2;
  localparam logic [2:0] ACT_INS_TAIL = 3'd3;
  localparam logic [2:0] ACT_DEL_IDX  = 3'd4;

  // Read value returned by a get that misses.
  localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;

  // Request fields.
  typedef struct packed {
    logic [2:0]               action;
    logic [CNT_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } in_req_t;

  // Result fields.
  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic                     rejected;
    logic [CNT_W-1:0]         entry_count;
  } out_rsp_t;

endpackage

// ===== sv/indexed_insert_delete_list_core.sv =====
// Indexed insert/delete list core: ordered list of signed values in a memory.
// Depends on ilst_pkg for the capacity, action codes and channel structs.
//
// Usage:
//   A request is taken on a rising edge where start is high and busy is low.
//   in_req carries the action, the position and the value to insert.
//   The core then raises busy and works on that one request alone.
//   Exactly one result follows: out_valid is high for a single cycle and
//   out_rsp holds read_value, rejected and the entry count after the action.
//   The receiver cannot stall, so the result must be taken in that cycle.
// Steps, from the accepting edge to the result strobe:
//   get, or any rejected request: decided in decode; a get hit then passes S_GET.
//   insert at position p with n entries held: n-p entries shift up first.
//   delete at position p with n entries held: n-p-1 entries shift down.
//   Every shifted entry takes one read and one write of the entry
//   memory, stepped by one shared index incrementer/decrementer.
// busy falls in the cycle the result is shown, so the next request may be
// taken while out_valid is high.
// Reset empties the list and returns the core to idle; the entry memory
// is not cleared, as only positions below the count are ever read.
module indexed_insert_delete_list_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ilst_pkg::in_req_t in_req,
  output logic              out_valid,
  output ilst_pkg::out_rsp_t out_rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_GET,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR
  } state_t;

  state_t                            state_r, state_nxt;
  ilst_pkg::in_req_t                 req_r;
  logic [ilst_pkg::CNT_W-1:0]        count_r, count_nxt;
  logic [ilst_pkg::IDX_W-1:0]        idx_r, idx_nxt;
  logic [ilst_pkg::CNT_W-1:0]        ins_pos_r, ins_pos_nxt;
  logic                              out_valid_r, out_valid_nxt;
  ilst_pkg::out_rsp_t                out_rsp_r, out_rsp_nxt;

  // Entry memory and its ports.
  logic [ilst_pkg::DATA_W-1:0]       mem [ilst_pkg::CAPACITY];
  logic                              mem_we, mem_re;
  logic [ilst_pkg::IDX_W-1:0]        mem_waddr, mem_raddr;
  logic [ilst_pkg::DATA_W-1:0]       mem_wdata;
  logic [ilst_pkg::DATA_W-1:0]       rd_data_r;

  // Shared step unit: the neighbor index while walking the list.
  logic [ilst_pkg::CNT_W-1:0]        idx_wide;
  logic [ilst_pkg::CNT_W-1:0]        idx_step;
  logic                              step_down;

  logic                              accept;
  logic [ilst_pkg::CNT_W-1:0]        eff_pos;
  logic                              list_full;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  assign idx_wide  = ilst_pkg::CNT_W'(idx_r);
  assign step_down = (state_r == S_INS_RD) || (state_r == S_INS_WR);
  assign idx_step  = step_down ? (idx_wide - ilst_pkg::CNT_W'(1))
                               : (idx_wide + ilst_pkg::CNT_W'(1));

  assign list_full = (count_r >= ilst_pkg::CNT_W'(ilst_pkg::CAPACITY));

  // Insert position after resolving head and tail inserts.
  always_comb begin
    case (req_r.action)
      ilst_pkg::ACT_INS_HEAD: eff_pos = '0;
      ilst_pkg::ACT_INS_TAIL: eff_pos = count_r;
      default:                eff_pos = req_r.position;
    endcase
  end

  // Sequencer: decode, then walk the list one entry per read/write pair.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    ins_pos_nxt   = ins_pos_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = idx_r;
    mem_raddr     = idx_step[ilst_pkg::IDX_W-1:0];
    mem_wdata     = rd_data_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        // Default result: a rejected request that leaves the list alone.
        out_rsp_nxt.read_value  = '0;
        out_rsp_nxt.rejected    = 1'b1;
        out_rsp_nxt.entry_count = count_r;
        case (req_r.action)
          ilst_pkg::ACT_GET: begin
            if (req_r.position < count_r) begin
              mem_re    = 1'b1;
              mem_raddr = req_r.position[ilst_pkg::IDX_W-1:0];
              state_nxt = S_GET;
            end else begin
              out_rsp_nxt.read_value = ilst_pkg::MISS_VALUE;
              out_valid_nxt          = 1'b1;
              state_nxt              = S_IDLE;
            end
          end
          ilst_pkg::ACT_INS_IDX, ilst_pkg::ACT_INS_HEAD,
          ilst_pkg::ACT_INS_TAIL: begin
            if ((eff_pos <= count_r) && !list_full) begin
              idx_nxt     = count_r[ilst_pkg::IDX_W-1:0];
              ins_pos_nxt = eff_pos;
              state_nxt   = S_INS_RD;
            end else begin
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          ilst_pkg::ACT_DEL_IDX: begin
            if (req_r.position < count_r) begin
              idx_nxt   = req_r.position[ilst_pkg::IDX_W-1:0];
              state_nxt = S_DEL_RD;
            end else begin
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        endcase
      end

      S_GET: begin
        out_rsp_nxt.read_value  = signed'(rd_data_r);
        out_rsp_nxt.rejected    = 1'b0;
        out_rsp_nxt.entry_count = count_r;
        out_valid_nxt           = 1'b1;
        state_nxt               = S_IDLE;
      end

      // Insert: move entries up from the tail until the hole reaches the position.
      S_INS_RD: begin
        if (idx_wide == ins_pos_r) begin
          mem_we                  = 1'b1;
          mem_wdata               = req_r.value;
          count_nxt               = count_r + ilst_pkg::CNT_W'(1);
          out_rsp_nxt.read_value  = '0;
          out_rsp_nxt.rejected    = 1'b0;
          out_rsp_nxt.entry_count = count_r + ilst_pkg::CNT_W'(1);
          out_valid_nxt           = 1'b1;
          state_nxt               = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          state_nxt = S_INS_WR;
        end
      end

      S_INS_WR: begin
        mem_we    = 1'b1;
        idx_nxt   = idx_step[ilst_pkg::IDX_W-1:0];
        state_nxt = S_INS_RD;
      end

      // Delete: move entries down one place until the old tail is reached.
      S_DEL_RD: begin
        if (idx_step >= count_r) begin
          count_nxt               = count_r - ilst_pkg::CNT_W'(1);
          out_rsp_nxt.read_value  = '0;
          out_rsp_nxt.rejected    = 1'b0;
          out_rsp_nxt.entry_count = count_r - ilst_pkg::CNT_W'(1);
          out_valid_nxt           = 1'b1;
          state_nxt               = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          state_nxt = S_DEL_WR;
        end
      end

      S_DEL_WR: begin
        mem_we    = 1'b1;
        idx_nxt   = idx_step[ilst_pkg::IDX_W-1:0];
        state_nxt = S_DEL_RD;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, count and registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (accept) begin
      req_r <= in_req;
    end
    idx_r     <= idx_nxt;
    ins_pos_r <= ins_pos_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // The count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ilst_pkg::CNT_W'(ilst_pkg::CAPACITY))
    else $error("entry count above capacity");

  // An accepted request keeps the core busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("core not busy after accepting a request");

  // A result is shown only once the sequencer has returned to idle.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy)
    else $error("result strobe while busy");

  // The count changes only together with a result strobe.
  a_count_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> out_valid_r)
    else $error("entry count changed without a result");

  // The reported count always matches the held count.
  a_count_reported: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_rsp_r.entry_count == count_r))
    else $error("reported entry count differs from held count");

endmodule

// ===== test/tb_indexed_insert_delete_list_core.sv =====
// Testbench for indexed_insert_delete_list_core: directed table, then random request phases.
// Each result is checked against a behavioral list model, or against a directed row's typed expectation.
// Depends on ilst_pkg for the capacity, action codes and request/result structs.
module tb_indexed_insert_delete_list_core;

  // Codes outside the defined action set.
  localparam logic [2:0] ACT_BAD_5 = 3'd5;
  localparam logic [2:0] ACT_BAD_6 = 3'd6;
  localparam logic [2:0] ACT_BAD_7 = 3'd7;

  // Random phase flavors.
  localparam int PH_GROW   = 0;
  localparam int PH_SHRINK = 1;
  localparam int PH_MIX    = 2;

  localparam int N_RANDOM     = 1300;
  localparam int QUIET_ITEMS  = 150;
  localparam int MAX_LATENCY  = 2 * ilst_pkg::CAPACITY + 3;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int N_DIRECTED   = 25;
  localparam int MAX_PRINTS   = 100;

  localparam ilst_pkg::out_rsp_t NO_CHECK = '0;

  typedef struct packed {
    ilst_pkg::in_req_t  req;
    logic               has_exp;
    ilst_pkg::out_rsp_t exp;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  ilst_pkg::in_req_t  in_req;
  logic               out_valid;
  ilst_pkg::out_rsp_t out_rsp;

  // Side information for the request now on the ports.
  logic               row_has_exp;
  ilst_pkg::out_rsp_t row_exp;

  // List model state and the results still owed by the core.
  logic signed [ilst_pkg::DATA_W-1:0] list_vals [ilst_pkg::CAPACITY];
  int                                 list_len;
  ilst_pkg::out_rsp_t                 pending_rsp [$];
  int unsigned                        accepted_cnt;
  int unsigned                        err_cnt;
  int unsigned                        cycle_cnt;

  indexed_insert_delete_list_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Directed requests; expectations are typed in only where they are obvious.
  dir_row_t dir_tab [N_DIRECTED] = '{
    '{'{ilst_pkg::ACT_GET,      7'd0,   32'sd0},       1'b1,
      '{ilst_pkg::MISS_VALUE, 1'b1, 7'd0}},
    '{'{ilst_pkg::ACT_DEL_IDX,  7'd0,   32'sd0},       1'b1, '{32'sd0, 1'b1, 7'd0}},
    '{'{ilst_pkg::ACT_INS_IDX,  7'd1,   32'sd5},       1'b1, '{32'sd0, 1'b1, 7'd0}},
    '{'{ilst_pkg::ACT_INS_IDX,  7'd0,   32'h7FFFFFFF}, 1'b1, '{32'sd0, 1'b0, 7'd1}},
    '{'{ilst_pkg::ACT_INS_HEAD, 7'd127, 32'h80000000}, 1'b1, '{32'sd0, 1'b0, 7'd2}},
    '{'{ilst_pkg::ACT_INS_TAIL, 7'd127, 32'hFFFFFFFF}, 1'b1, '{32'sd0, 1'b0, 7'd3}},
    '{'{ilst_pkg::ACT_INS_IDX,  7'd3,   32'sd0},       1'b1, '{32'sd0, 1'b0, 7'd4}},
    '{'{ilst_pkg::ACT_INS_IDX,  7'd1,   32'h12345678}, 1'b1, '{32'sd0, 1'b0, 7'd5}},
    '{'{ilst_pkg::ACT_GET,      7'd0,   32'h5A5A5A5A}, 1'b0, NO_CHECK},
    '{'{ilst_pkg::ACT_GET,      7'd2,   32'sd0},       1'b0, NO_CHECK},
    '{'{ilst_pkg::ACT_GET,      7'd4,   32'sd0},       1'b0, NO_CHECK},
    '{'{ilst_pkg::ACT_GET,      7'd5,   32'sd0},       1'b1,
      '{ilst_pkg::MISS_VALUE, 1'b1, 7'd5}},
    '{'{ilst_pkg::ACT_GET,      7'd127, 32'sd0},       1'b1,
      '{ilst_pkg::MISS_VALUE, 1'b1, 7'd5}},
    '{'{ACT_BAD_5,              7'd0,   32'sd1},       1'b1, '{32'sd0, 1'b1, 7'd5}},
    '{'{ACT_BAD_6,              7'd127, 32'hFFFFFFFF}, 1'b1, '{32'sd0, 1'b1, 7'd5}},
    '{'{ACT_BAD_7,              7'd2,   32'h0F0F0F0F}, 1'b1, '{32'sd0, 1'b1, 7'd5}},
    '{'{ilst_pkg::ACT_DEL_IDX,  7'd5,   32'sd0},       1'b1, '{32'sd0, 1'b1, 7'd5}},
    '{'{ilst_pkg::ACT_DEL_IDX,  7'd127, 32'sd0},       1'b1, '{32'sd0, 1'b1, 7'd5}},
    '{'{ilst_pkg::ACT_INS_IDX,  7'd6,   32'sd9},       1'b1, '{32'sd0, 1'b1, 7'd5}},
    '{'{ilst_pkg::ACT_INS_IDX,  7'd127, 32'sd9},       1'b1, '{32'sd0, 1'b1, 7'd5}},
    '{'{ilst_pkg::ACT_DEL_IDX,  7'd0,   32'sd0},       1'b0, NO_CHECK},
    '{'{ilst_pkg::ACT_DEL_IDX,  7'd3,   32'sd0},       1'b0, NO_CHECK},
    '{'{ilst_pkg::ACT_DEL_IDX,  7'd1,   32'sd0},       1'b0, NO_CHECK},
    '{'{ilst_pkg::ACT_GET,      7'd1,   32'sd0},       1'b0, NO_CHECK},
    '{'{ilst_pkg::ACT_GET,      7'd0,   32'sd0},       1'b0, NO_CHECK}
  };

  // Applies one request to the list model and returns the result it owes.
  function automatic ilst_pkg::out_rsp_t apply_request(ilst_pkg::in_req_t r);
    ilst_pkg::out_rsp_t rsp;
    int                 p;
    int                 ip;
    int                 i;
    rsp = '0;
    p   = int'(r.position);
    case (r.action)
      ilst_pkg::ACT_GET: begin
        if (p < list_len) begin
          rsp.read_value = list_vals[p];
        end else begin
          rsp.read_value = ilst_pkg::MISS_VALUE;
          rsp.rejected   = 1'b1;
        end
      end
      ilst_pkg::ACT_INS_IDX, ilst_pkg::ACT_INS_HEAD, ilst_pkg::ACT_INS_TAIL: begin
        ip = p;
        if (r.action == ilst_pkg::ACT_INS_HEAD) ip = 0;
        if (r.action == ilst_pkg::ACT_INS_TAIL) ip = list_len;
        if (ip > list_len || list_len >= ilst_pkg::CAPACITY) begin
          rsp.rejected = 1'b1;
        end else begin
          for (i = list_len; i > ip; i--) list_vals[i] = list_vals[i-1];
          list_vals[ip] = r.value;
          list_len++;
        end
      end
      ilst_pkg::ACT_DEL_IDX: begin
        if (p >= list_len) begin
          rsp.rejected = 1'b1;
        end else begin
          for (i = p; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end
      end
      default: begin
        rsp.rejected = 1'b1;
      end
    endcase
    rsp.entry_count = list_len[ilst_pkg::CNT_W-1:0];
    return rsp;
  endfunction

  // Prints one line per mismatch, up to a cap, and counts all of them.
  task automatic report_mismatch(input string what, input longint got,
                                 input longint want);
    if (err_cnt < MAX_PRINTS)
      $display("[%0t] mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    err_cnt++;
  endtask

  // Sample results and accepted requests on the rising edge.
  always @(posedge clk) begin
    ilst_pkg::out_rsp_t want;
    ilst_pkg::out_rsp_t model_rsp;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_rsp.size() == 0) begin
          report_mismatch("result with no request pending", longint'(out_rsp), 64'sd0);
        end else begin
          want = pending_rsp.pop_front();
          if (out_rsp.read_value !== want.read_value)
            report_mismatch("read_value", longint'(out_rsp.read_value),
                            longint'(want.read_value));
          if (out_rsp.rejected !== want.rejected)
            report_mismatch("rejected", longint'(out_rsp.rejected),
                            longint'(want.rejected));
          if (out_rsp.entry_count !== want.entry_count)
            report_mismatch("entry_count", longint'(out_rsp.entry_count),
                            longint'(want.entry_count));
        end
      end
      if (start && !busy) begin
        model_rsp = apply_request(in_req);
        pending_rsp.push_back(row_has_exp ? row_exp : model_rsp);
        accepted_cnt++;
      end
    end
  end

  // Guard against a hung core.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // Holds one request on the ports until the core takes it; called at a falling edge.
  task automatic send_req(input ilst_pkg::in_req_t r, input logic chk,
                          input ilst_pkg::out_rsp_t rsp);
    int unsigned seen;
    seen        = accepted_cnt;
    in_req      = r;
    row_has_exp = chk;
    row_exp     = rsp;
    start       = 1'b1;
    do @(negedge clk); while (accepted_cnt == seen);
    row_has_exp = 1'b0;
  endtask

  // Sometimes drops start for a random burst, with junk on the request bus.
  task automatic idle_gap(input logic allowed);
    int          n;
    logic [63:0] junk;
    if (allowed && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      n = $urandom_range(1, 16);
      repeat (n) begin
        junk   = {$urandom, $urandom};
        in_req = junk[$bits(ilst_pkg::in_req_t)-1:0];
        @(negedge clk);
      end
    end
  endtask

  // Stop sending until every owed result has come back.
  task automatic drain_results();
    start = 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
  endtask

  // Stimulus.
  initial begin
    ilst_pkg::in_req_t r;
    int                item;
    int                kind;
    int                phase_len;
    int                k;
    int                sel;
    int                ins_lim;
    int                del_lim;
    int                which;
    logic              first;

    rst_n        = 1'b0;
    start        = 1'b0;
    in_req       = '0;
    row_has_exp  = 1'b0;
    row_exp      = '0;
    list_len     = 0;
    accepted_cnt = 0;
    err_cnt      = 0;
    cycle_cnt    = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table.
    for (k = 0; k < N_DIRECTED; k++) begin
      send_req(dir_tab[k].req, dir_tab[k].has_exp, dir_tab[k].exp);
      idle_gap(1'b1);
    end
    drain_results();

    // Random phases; the first one is a growing phase.
    item  = 0;
    first = 1'b1;
    while (item < N_RANDOM) begin
      kind      = first ? PH_GROW : $urandom_range(0, 2);
      first     = 1'b0;
      phase_len = $urandom_range(30, 120);
      case (kind)
        PH_GROW: begin
          ins_lim = 75;
          del_lim = 88;
        end
        PH_SHRINK: begin
          ins_lim = 10;
          del_lim = 80;
        end
        default: begin
          ins_lim = 40;
          del_lim = 70;
        end
      endcase
      for (k = 0; k < phase_len && item < N_RANDOM; k++) begin
        sel        = $urandom_range(0, 99);
        r.value    = $urandom;
        r.position = ilst_pkg::CNT_W'($urandom_range(0, 127));
        if (sel < 5) begin
          // Noise: any code, and a position at the edge or anywhere.
          r.action = 3'($urandom_range(0, 7));
          if ($urandom_range(0, 1)) r.position = ilst_pkg::CNT_W'(list_len);
        end else if (sel < ins_lim) begin
          which = $urandom_range(0, 2);
          if (which == 0) begin
            r.action   = ilst_pkg::ACT_INS_IDX;
            r.position = ilst_pkg::CNT_W'($urandom_range(0, list_len));
          end else if (which == 1) begin
            r.action = ilst_pkg::ACT_INS_HEAD;
          end else begin
            r.action = ilst_pkg::ACT_INS_TAIL;
          end
        end else begin
          r.action   = (sel < del_lim) ? ilst_pkg::ACT_DEL_IDX : ilst_pkg::ACT_GET;
          r.position = (list_len > 0) ?
                       ilst_pkg::CNT_W'($urandom_range(0, list_len - 1)) : '0;
        end
        send_req(r, 1'b0, NO_CHECK);
        item++;
        idle_gap(item < N_RANDOM - QUIET_ITEMS);
      end
      if (item < N_RANDOM - QUIET_ITEMS && $urandom_range(0, 1)) drain_results();
    end

    // Wrap up: wait for all results, then for any stray strobe.
    start = 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (MAX_LATENCY) @(negedge clk);
    if (pending_rsp.size() != 0)
      report_mismatch("results never returned", longint'(pending_rsp.size()), 64'sd0);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/ilst_pkg.sv
sv/indexed_insert_delete_list_core.sv
test/tb_indexed_insert_delete_list_core.sv
